FILE: rtl/core/frs_pkg.sv
// Shared widths, constants and the context record for the Fresnel reflectance pipeline.
// Depends on nothing; every other file in rtl/core uses it.
`default_nettype none

package frs_pkg;

  // Field widths.
  localparam int unsigned VEC_W  = 16;
  localparam int unsigned ETA_W  = 16;
  localparam int unsigned REFL_W = 16;

  // Internal widths.
  localparam int unsigned PROD_W  = 32;  // one Q2.14 by Q2.14 product
  localparam int unsigned DOT_W   = 34;  // sum of three products
  localparam int unsigned CA_W    = 29;  // |cos_i| in Q.28, up to 2^28
  localparam int unsigned SQ_W    = 58;  // cos_i squared
  localparam int unsigned ETA2_W  = 32;  // squared index
  localparam int unsigned P_W     = 61;  // eta_i^2 * sin_i^2
  localparam int unsigned DIV_W   = 46;  // divisor and remainder width of the shared step
  localparam int unsigned ST2_W   = 28;  // sin_t^2 quotient bits
  localparam int unsigned CT_W    = 29;  // cos_t in Q.28
  localparam int unsigned RAD_W   = 58;  // radicand for cos_t
  localparam int unsigned SQR_W   = 32;  // square root remainder
  localparam int unsigned SQRT_STEPS = 29;
  localparam int unsigned TERM_W  = 45;  // eta times cosine
  localparam int unsigned RQ_W    = 17;  // |Rs|, |Rp| in Q.16
  localparam int unsigned RSQ_W   = 34;
  localparam int unsigned SUM_W   = 35;

  // Register stages from input transaction to result strobe.
  localparam int unsigned PIPE_DEPTH = 6 + ST2_W + 1 + SQRT_STEPS + 2 + RQ_W + 2;

  localparam logic [CA_W-1:0]   ONE_Q28  = 29'd268435456;
  localparam logic [ETA_W-1:0]  ONE_Q12  = 16'd4096;
  localparam logic [REFL_W-1:0] FULL_Q15 = 16'd32768;
  localparam logic [SUM_W-1:0]  HALF_LSB = 35'd65536;

  // Per item data that rides along the pipeline.
  typedef struct packed {
    logic             tir;
    logic [ETA_W-1:0] eta_i;
    logic [ETA_W-1:0] eta_t;
    logic [CA_W-1:0]  cos_i;
  } frs_ctx_t;

endpackage

`default_nettype wire

FILE: rtl/core/frs_div_step.sv
// One restoring division step: shifts in a dividend bit and subtracts when it fits.
// Depends on frs_pkg for the remainder width.
`default_nettype none

module frs_div_step (
  input  logic [frs_pkg::DIV_W-1:0] rem_i,
  input  logic                      bit_i,
  input  logic [frs_pkg::DIV_W-1:0] div_i,
  output logic [frs_pkg::DIV_W-1:0] rem_o,
  output logic                      q_o
);

  logic [frs_pkg::DIV_W:0] trial;
  logic [frs_pkg::DIV_W:0] diff;

  // Partial remainder with the next bit, and the trial subtraction.
  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, div_i};
  assign q_o   = (trial >= {1'b0, div_i});
  assign rem_o = q_o ? diff[frs_pkg::DIV_W-1:0] : trial[frs_pkg::DIV_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/frs_sqrt_step.sv
// One digit-by-digit square root step: brings in two radicand bits, yields one root bit.
// Depends on frs_pkg for widths.
`default_nettype none

module frs_sqrt_step (
  input  logic [frs_pkg::SQR_W-1:0] rem_i,
  input  logic [frs_pkg::CT_W-1:0]  root_i,
  input  logic [1:0]                pair_i,
  output logic [frs_pkg::SQR_W-1:0] rem_o,
  output logic [frs_pkg::CT_W-1:0]  root_o
);

  logic [frs_pkg::SQR_W-1:0] shifted;
  logic [frs_pkg::SQR_W-1:0] trial;
  logic [frs_pkg::SQR_W-1:0] diff;
  logic                      fits;

  // The trial value is four times the root plus one.
  assign shifted = {rem_i[frs_pkg::SQR_W-3:0], pair_i};
  assign trial   = {1'b0, root_i, 2'b01};
  assign diff    = shifted - trial;
  assign fits    = (shifted >= trial);
  assign rem_o   = fits ? diff : shifted;
  assign root_o  = {root_i[frs_pkg::CT_W-2:0], fits};

endmodule

`default_nettype wire

FILE: rtl/core/frs_snell.sv
// Front of the pipeline: dot product, clamp, index swap, total internal reflection
// test and the sin_t^2 division, ending in cos_t^2. Depends on frs_pkg, frs_div_step.
`default_nettype none

module frs_snell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_x_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_y_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_z_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_x_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_y_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_z_i,
  input  logic        [frs_pkg::ETA_W-1:0]  refr_index_i,
  output logic                              valid_o,
  output frs_pkg::frs_ctx_t                 ctx_o,
  output logic        [frs_pkg::CA_W-1:0]   ct2_o
);

  localparam logic signed [frs_pkg::DOT_W-1:0] LIM = 34'sd268435456;

  // Stage A: component products.
  logic                               a_v_q;
  logic signed [frs_pkg::PROD_W-1:0]  a_px_q, a_py_q, a_pz_q;
  logic        [frs_pkg::ETA_W-1:0]   a_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_px_q  <= dir_x_i * norm_x_i;
    a_py_q  <= dir_y_i * norm_y_i;
    a_pz_q  <= dir_z_i * norm_z_i;
    a_idx_q <= (refr_index_i == '0) ? 16'd1 : refr_index_i;
  end

  // Stage B: sum, clamp to one, and swap indices for a ray that leaves.
  logic signed [frs_pkg::DOT_W-1:0] b_dot;
  logic signed [frs_pkg::DOT_W-1:0] b_neg;
  logic        [frs_pkg::CA_W-1:0]  b_ca;
  logic                             b_pos;
  logic                             b_v_q;
  frs_pkg::frs_ctx_t                b_ctx_d, b_ctx_q;

  always_comb begin
    b_dot = {{2{a_px_q[frs_pkg::PROD_W-1]}}, a_px_q}
          + {{2{a_py_q[frs_pkg::PROD_W-1]}}, a_py_q}
          + {{2{a_pz_q[frs_pkg::PROD_W-1]}}, a_pz_q};
    b_neg = -b_dot;
    b_pos = (b_dot > 0);
    if (b_pos) begin
      b_ca = (b_dot >= LIM) ? frs_pkg::ONE_Q28 : b_dot[frs_pkg::CA_W-1:0];
    end else begin
      b_ca = (b_neg >= LIM) ? frs_pkg::ONE_Q28 : b_neg[frs_pkg::CA_W-1:0];
    end
    b_ctx_d.tir   = 1'b0;
    b_ctx_d.cos_i = b_ca;
    b_ctx_d.eta_i = b_pos ? a_idx_q : frs_pkg::ONE_Q12;
    b_ctx_d.eta_t = b_pos ? frs_pkg::ONE_Q12 : a_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_ctx_q <= b_ctx_d;
  end

  // Stage C: cos_i squared and the squared indices.
  logic                               c_v_q;
  frs_pkg::frs_ctx_t                  c_ctx_q;
  logic [frs_pkg::SQ_W-1:0]           c_sq_q;
  logic [frs_pkg::ETA2_W-1:0]         c_ei2_q, c_et2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_ctx_q <= b_ctx_q;
    c_sq_q  <= {29'd0, b_ctx_q.cos_i} * {29'd0, b_ctx_q.cos_i};
    c_ei2_q <= {16'd0, b_ctx_q.eta_i} * {16'd0, b_ctx_q.eta_i};
    c_et2_q <= {16'd0, b_ctx_q.eta_t} * {16'd0, b_ctx_q.eta_t};
  end

  // Stage D: sin_i^2 in Q.28.
  logic                         d_v_q;
  frs_pkg::frs_ctx_t            d_ctx_q;
  logic [frs_pkg::CA_W-1:0]     d_s2_q;
  logic [frs_pkg::ETA2_W-1:0]   d_ei2_q, d_et2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_ctx_q <= c_ctx_q;
    d_s2_q  <= frs_pkg::ONE_Q28 - c_sq_q[56:28];
    d_ei2_q <= c_ei2_q;
    d_et2_q <= c_et2_q;
  end

  // Stage E: eta_i^2 * sin_i^2.
  logic                         e_v_q;
  frs_pkg::frs_ctx_t            e_ctx_q;
  logic [frs_pkg::P_W-1:0]      e_p_q;
  logic [frs_pkg::ETA2_W-1:0]   e_et2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else begin
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_ctx_q <= d_ctx_q;
    e_p_q   <= {29'd0, d_ei2_q} * {32'd0, d_s2_q};
    e_et2_q <= d_et2_q;
  end

  // Stage F: total internal reflection test and division setup.
  // Outside that case the quotient is below 2^28, so the top dividend bits
  // already sit below the divisor.
  logic                        dv_v_q   [frs_pkg::ST2_W+1];
  frs_pkg::frs_ctx_t           dv_ctx_q [frs_pkg::ST2_W+1];
  logic [frs_pkg::DIV_W-1:0]   dv_rem_q [frs_pkg::ST2_W+1];
  logic [frs_pkg::DIV_W-1:0]   dv_div_q [frs_pkg::ST2_W+1];
  logic [frs_pkg::ST2_W-1:0]   dv_low_q [frs_pkg::ST2_W+1];
  logic [frs_pkg::ST2_W-1:0]   dv_quo_q [frs_pkg::ST2_W+1];
  frs_pkg::frs_ctx_t           f_ctx_d;

  always_comb begin
    f_ctx_d     = e_ctx_q;
    f_ctx_d.tir = (e_p_q >= {1'b0, e_et2_q, 28'd0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_ctx_q[0] <= f_ctx_d;
    dv_rem_q[0] <= {13'd0, e_p_q[60:28]};
    dv_div_q[0] <= {14'd0, e_et2_q};
    dv_low_q[0] <= e_p_q[27:0];
    dv_quo_q[0] <= '0;
  end

  // Division stages, one quotient bit each.
  for (genvar k = 0; k < frs_pkg::ST2_W; k++) begin : g_div
    logic [frs_pkg::DIV_W-1:0] rem_nx;
    logic                      q_bit;

    frs_div_step u_step (
      .rem_i (dv_rem_q[k]),
      .bit_i (dv_low_q[k][frs_pkg::ST2_W-1]),
      .div_i (dv_div_q[k]),
      .rem_o (rem_nx),
      .q_o   (q_bit)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_ctx_q[k+1] <= dv_ctx_q[k];
      dv_rem_q[k+1] <= rem_nx;
      dv_div_q[k+1] <= dv_div_q[k];
      dv_low_q[k+1] <= {dv_low_q[k][frs_pkg::ST2_W-2:0], 1'b0};
      dv_quo_q[k+1] <= {dv_quo_q[k][frs_pkg::ST2_W-2:0], q_bit};
    end
  end

  // Stage G: cos_t^2 = 1 - sin_t^2.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_v_q[frs_pkg::ST2_W];
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_o <= dv_ctx_q[frs_pkg::ST2_W];
    ct2_o <= frs_pkg::ONE_Q28 - {1'b0, dv_quo_q[frs_pkg::ST2_W]};
  end

endmodule

`default_nettype wire

FILE: rtl/core/frs_cos_t.sv
// Square root pipeline: cos_t = floor(sqrt(cos_t^2 * 2^28)), one root bit per stage.
// Depends on frs_pkg and frs_sqrt_step.
`default_nettype none

module frs_cos_t (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  frs_pkg::frs_ctx_t          ctx_i,
  input  logic [frs_pkg::CA_W-1:0]   ct2_i,
  output logic                       valid_o,
  output frs_pkg::frs_ctx_t          ctx_o,
  output logic [frs_pkg::CT_W-1:0]   ct_o
);

  logic                       sq_v   [frs_pkg::SQRT_STEPS+1];
  frs_pkg::frs_ctx_t          sq_ctx [frs_pkg::SQRT_STEPS+1];
  logic [frs_pkg::RAD_W-1:0]  sq_rad [frs_pkg::SQRT_STEPS+1];
  logic [frs_pkg::SQR_W-1:0]  sq_rem [frs_pkg::SQRT_STEPS+1];
  logic [frs_pkg::CT_W-1:0]   sq_root[frs_pkg::SQRT_STEPS+1];

  // The radicand is cos_t^2 shifted up by 28 bits.
  assign sq_v[0]    = valid_i;
  assign sq_ctx[0]  = ctx_i;
  assign sq_rad[0]  = {1'b0, ct2_i, 28'd0};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < frs_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [frs_pkg::SQR_W-1:0] rem_nx;
    logic [frs_pkg::CT_W-1:0]  root_nx;

    frs_sqrt_step u_step (
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .pair_i (sq_rad[k][frs_pkg::RAD_W-1 -: 2]),
      .rem_o  (rem_nx),
      .root_o (root_nx)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_ctx[k+1]  <= sq_ctx[k];
      sq_rad[k+1]  <= {sq_rad[k][frs_pkg::RAD_W-3:0], 2'b00};
      sq_rem[k+1]  <= rem_nx;
      sq_root[k+1] <= root_nx;
    end
  end

  assign valid_o = sq_v[frs_pkg::SQRT_STEPS];
  assign ctx_o   = sq_ctx[frs_pkg::SQRT_STEPS];
  assign ct_o    = sq_root[frs_pkg::SQRT_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/frs_coef.sv
// Back of the pipeline: Rs and Rp amplitude ratios, their squares and the rounded
// Q1.15 reflectance. Depends on frs_pkg and frs_div_step.
`default_nettype none

module frs_coef (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  frs_pkg::frs_ctx_t            ctx_i,
  input  logic [frs_pkg::CT_W-1:0]     ct_i,
  output logic                         valid_o,
  output logic [frs_pkg::REFL_W-1:0]   reflectance_o,
  output logic                         total_internal_o
);

  // Stage H: the four index-cosine terms.
  logic                         h_v_q, h_tir_q;
  logic [frs_pkg::TERM_W-1:0]   h_etci_q, h_eict_q, h_eici_q, h_etct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else begin
      h_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    h_tir_q  <= ctx_i.tir;
    h_etci_q <= {29'd0, ctx_i.eta_t} * {16'd0, ctx_i.cos_i};
    h_eict_q <= {29'd0, ctx_i.eta_i} * {16'd0, ct_i};
    h_eici_q <= {29'd0, ctx_i.eta_i} * {16'd0, ctx_i.cos_i};
    h_etct_q <= {29'd0, ctx_i.eta_t} * {16'd0, ct_i};
  end

  // Stage I: magnitudes of the numerators, denominators, divider setup.
  // The magnitude never exceeds the denominator, so the quotient fits 17 bits.
  logic [frs_pkg::DIV_W-1:0] i_ns, i_np, i_as, i_ap;

  always_comb begin
    i_ns = {1'b0, h_etci_q} - {1'b0, h_eict_q};
    i_np = {1'b0, h_eici_q} - {1'b0, h_etct_q};
    i_as = i_ns[frs_pkg::DIV_W-1] ? -i_ns : i_ns;
    i_ap = i_np[frs_pkg::DIV_W-1] ? -i_np : i_np;
  end

  logic                        rd_v    [frs_pkg::RQ_W+1];
  logic                        rd_tir  [frs_pkg::RQ_W+1];
  logic [frs_pkg::DIV_W-1:0]   rd_rems [frs_pkg::RQ_W+1];
  logic [frs_pkg::DIV_W-1:0]   rd_remp [frs_pkg::RQ_W+1];
  logic [frs_pkg::DIV_W-1:0]   rd_dens [frs_pkg::RQ_W+1];
  logic [frs_pkg::DIV_W-1:0]   rd_denp [frs_pkg::RQ_W+1];
  logic [frs_pkg::RQ_W-1:0]    rd_lows [frs_pkg::RQ_W+1];
  logic [frs_pkg::RQ_W-1:0]    rd_lowp [frs_pkg::RQ_W+1];
  logic [frs_pkg::RQ_W-1:0]    rd_quos [frs_pkg::RQ_W+1];
  logic [frs_pkg::RQ_W-1:0]    rd_quop [frs_pkg::RQ_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v[0] <= 1'b0;
    end else begin
      rd_v[0] <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tir[0]  <= h_tir_q;
    rd_rems[0] <= {1'b0, i_as[frs_pkg::DIV_W-1:1]};
    rd_remp[0] <= {1'b0, i_ap[frs_pkg::DIV_W-1:1]};
    rd_dens[0] <= {1'b0, h_etci_q} + {1'b0, h_eict_q};
    rd_denp[0] <= {1'b0, h_eici_q} + {1'b0, h_etct_q};
    rd_lows[0] <= {i_as[0], 16'd0};
    rd_lowp[0] <= {i_ap[0], 16'd0};
    rd_quos[0] <= '0;
    rd_quop[0] <= '0;
  end

  // Two dividers side by side, one quotient bit per stage.
  for (genvar k = 0; k < frs_pkg::RQ_W; k++) begin : g_div
    logic [frs_pkg::DIV_W-1:0] rems_nx, remp_nx;
    logic                      qs_bit, qp_bit;

    frs_div_step u_step_s (
      .rem_i (rd_rems[k]),
      .bit_i (rd_lows[k][frs_pkg::RQ_W-1]),
      .div_i (rd_dens[k]),
      .rem_o (rems_nx),
      .q_o   (qs_bit)
    );

    frs_div_step u_step_p (
      .rem_i (rd_remp[k]),
      .bit_i (rd_lowp[k][frs_pkg::RQ_W-1]),
      .div_i (rd_denp[k]),
      .rem_o (remp_nx),
      .q_o   (qp_bit)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rd_v[k+1] <= 1'b0;
      end else begin
        rd_v[k+1] <= rd_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rd_tir[k+1]  <= rd_tir[k];
      rd_rems[k+1] <= rems_nx;
      rd_remp[k+1] <= remp_nx;
      rd_dens[k+1] <= rd_dens[k];
      rd_denp[k+1] <= rd_denp[k];
      rd_lows[k+1] <= {rd_lows[k][frs_pkg::RQ_W-2:0], 1'b0};
      rd_lowp[k+1] <= {rd_lowp[k][frs_pkg::RQ_W-2:0], 1'b0};
      rd_quos[k+1] <= {rd_quos[k][frs_pkg::RQ_W-2:0], qs_bit};
      rd_quop[k+1] <= {rd_quop[k][frs_pkg::RQ_W-2:0], qp_bit};
    end
  end

  // Stage J: squares of the two ratios.
  logic                        j_v_q, j_tir_q;
  logic [frs_pkg::RSQ_W-1:0]   j_rs2_q, j_rp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_v_q <= 1'b0;
    end else begin
      j_v_q <= rd_v[frs_pkg::RQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    j_tir_q <= rd_tir[frs_pkg::RQ_W];
    j_rs2_q <= {17'd0, rd_quos[frs_pkg::RQ_W]} * {17'd0, rd_quos[frs_pkg::RQ_W]};
    j_rp2_q <= {17'd0, rd_quop[frs_pkg::RQ_W]} * {17'd0, rd_quop[frs_pkg::RQ_W]};
  end

  // Stage K: average with rounding, saturation, and the total reflection override.
  logic [frs_pkg::SUM_W-1:0]  k_sum;
  logic [17:0]                k_r;
  logic [frs_pkg::REFL_W-1:0] k_refl;

  always_comb begin
    k_sum = {1'b0, j_rs2_q} + {1'b0, j_rp2_q} + frs_pkg::HALF_LSB;
    k_r   = k_sum[frs_pkg::SUM_W-1:17];
    if (j_tir_q || (k_r > {2'b00, frs_pkg::FULL_Q15})) begin
      k_refl = frs_pkg::FULL_Q15;
    end else begin
      k_refl = k_r[frs_pkg::REFL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= j_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    reflectance_o    <= k_refl;
    total_internal_o <= j_tir_q;
  end

endmodule

`default_nettype wire

FILE: rtl/core/fresnel_reflectance.sv
// Top level of the unpolarized Fresnel reflectance pipeline.
// Depends on frs_pkg, frs_snell, frs_cos_t and frs_coef.
//
// A new transaction is taken in every clock cycle: busy_o is always low, so each
// cycle with start_i high is one accepted item. Its result appears on valid_o,
// reflectance_o and total_internal_o after the frs_pkg::PIPE_DEPTH register stages,
// for one cycle, in input order. Those stages are set by the bit-per-stage
// pipelines: 28 stages for the sin_t^2 division, 29 for the cos_t square root and
// 17 for the Rs and Rp divisions, plus 11 arithmetic stages. The receiver cannot
// stall, so results must be captured in the cycle that valid_o is high.
`default_nettype none

module fresnel_reflectance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_x_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_y_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_z_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_x_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_y_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_z_i,
  input  logic        [frs_pkg::ETA_W-1:0]  refr_index_i,
  output logic                              valid_o,
  output logic        [frs_pkg::REFL_W-1:0] reflectance_o,
  output logic                              total_internal_o
);

  logic                      sn_valid, ct_valid;
  frs_pkg::frs_ctx_t         sn_ctx, ct_ctx;
  logic [frs_pkg::CA_W-1:0]  sn_ct2;
  logic [frs_pkg::CT_W-1:0]  ct_val;

  // The pipeline never holds off a transaction.
  assign busy_o = 1'b0;

  frs_snell u_snell (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start_i & ~busy_o),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .norm_x_i     (norm_x_i),
    .norm_y_i     (norm_y_i),
    .norm_z_i     (norm_z_i),
    .refr_index_i (refr_index_i),
    .valid_o      (sn_valid),
    .ctx_o        (sn_ctx),
    .ct2_o        (sn_ct2)
  );

  frs_cos_t u_cos_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sn_valid),
    .ctx_i   (sn_ctx),
    .ct2_i   (sn_ct2),
    .valid_o (ct_valid),
    .ctx_o   (ct_ctx),
    .ct_o    (ct_val)
  );

  frs_coef u_coef (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (ct_valid),
    .ctx_i            (ct_ctx),
    .ct_i             (ct_val),
    .valid_o          (valid_o),
    .reflectance_o    (reflectance_o),
    .total_internal_o (total_internal_o)
  );

  // Total internal reflection always reports full reflectance.
  a_tir_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && total_internal_o) |-> (reflectance_o == frs_pkg::FULL_Q15))
    else $error("total internal reflection without full reflectance");

  // Reflectance never exceeds one.
  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (reflectance_o <= frs_pkg::FULL_Q15))
    else $error("reflectance above one");

  // After the square root, cos_t is positive whenever the ray refracts.
  a_cos_t_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ct_valid && !ct_ctx.tir) |-> (ct_val != '0))
    else $error("zero cos_t on a refracted ray");

endmodule

`default_nettype wire

FILE: verif/fresnel_reflectance_checker.sv
// Checker for the Fresnel reflectance block: watches the input and result channels,
// computes the expected reflectance of each accepted ray, and compares. Uses frs_pkg.
`default_nettype none

module fresnel_reflectance_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_x_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_y_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  dir_z_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_x_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_y_i,
  input  logic signed [frs_pkg::VEC_W-1:0]  norm_z_i,
  input  logic        [frs_pkg::ETA_W-1:0]  refr_index_i,
  input  logic                              valid_i,
  input  logic        [frs_pkg::REFL_W-1:0] reflectance_i,
  input  logic                              total_internal_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                tir_seen_o,
  output int                                results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [frs_pkg::REFL_W-1:0] refl;
    logic                       tir;
  } refl_result_t;

  refl_result_t refl_queue[$];

  assign pending_o = refl_queue.size();

  // Integer square root, floor.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Magnitude of num/den in Q.16; a nonpositive denominator reads as 1.0.
  function automatic longint unsigned amp_q16(longint num, longint den);
    longint unsigned mag;
    mag = (num < 0) ? -num : num;
    if (den <= 0) return 64'd1 << 16;
    return (mag << 16) / den;
  endfunction

  // Expected reflectance of one ray hit.
  function automatic refl_result_t fresnel_predict(
      logic signed [15:0] dx, dy, dz, nx, ny, nz, logic [15:0] idx);
    refl_result_t res;
    longint cosv, one_q28;
    longint unsigned eta_in, eta_out, swap, ca, sin2, st2, ct, rs, rp, r;
    one_q28 = 64'sd1 << 28;
    cosv = longint'(dx) * nx + longint'(dy) * ny + longint'(dz) * nz;
    if (cosv > one_q28) cosv = one_q28;
    if (cosv < -one_q28) cosv = -one_q28;
    eta_in = frs_pkg::ONE_Q12;
    eta_out = (idx == 0) ? 1 : idx;
    // A positive cosine means the ray exits the material.
    if (cosv > 0) begin
      swap = eta_in;
      eta_in = eta_out;
      eta_out = swap;
    end
    ca = (cosv < 0) ? -cosv : cosv;
    sin2 = (64'd1 << 28) - ((ca * ca) >> 28);
    if (eta_in * eta_in * sin2 >= ((eta_out * eta_out) << 28)) begin
      res.refl = frs_pkg::FULL_Q15;
      res.tir = 1'b1;
      return res;
    end
    st2 = (eta_in * eta_in * sin2) / (eta_out * eta_out);
    ct = floor_sqrt(((64'd1 << 28) - st2) << 28);
    rs = amp_q16(longint'(eta_out * ca) - longint'(eta_in * ct),
                 longint'(eta_out * ca) + longint'(eta_in * ct));
    rp = amp_q16(longint'(eta_in * ca) - longint'(eta_out * ct),
                 longint'(eta_in * ca) + longint'(eta_out * ct));
    r = (rs * rs + rp * rp + (64'd1 << 16)) >> 17;
    if (r > frs_pkg::FULL_Q15) r = frs_pkg::FULL_Q15;
    res.refl = r[15:0];
    res.tir = 1'b0;
    return res;
  endfunction

  // Predict on each accepted transaction and compare each result strobe.
  always @(posedge clk_i) begin
    refl_result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      tir_seen_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (valid_i) begin
        results_seen_o <= results_seen_o + 1;
        if (total_internal_i) tir_seen_o <= tir_seen_o + 1;
        if (refl_queue.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result: refl %0d tir %0b",
                                          reflectance_i, total_internal_i);
        end else begin
          want = refl_queue.pop_front();
          if (want.refl !== reflectance_i || want.tir !== total_internal_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected refl %0d tir %0b, got refl %0d tir %0b",
                       want.refl, want.tir, reflectance_i, total_internal_i);
          end
        end
      end
      if (start_i && !busy_i)
        refl_queue.push_back(fresnel_predict(dir_x_i, dir_y_i, dir_z_i, norm_x_i,
                                             norm_y_i, norm_z_i, refr_index_i));
    end
  end

endmodule

`default_nettype wire

FILE: verif/fresnel_reflectance_test.sv
// Top of the Fresnel reflectance testbench: clock, reset, ray stimulus and verdict.
// Depends on frs_pkg, fresnel_reflectance and fresnel_reflectance_checker.
`default_nettype none

module fresnel_reflectance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_RAYS = 1830;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk, rst_n, start, busy, valid, tir;
  logic signed [15:0] dx, dy, dz, nx, ny, nz;
  logic [15:0] idx, refl;
  int fail_count, pending, tir_seen, results_seen, idle_cycles, ray_count;

  fresnel_reflectance dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .dir_x_i(dx), .dir_y_i(dy), .dir_z_i(dz),
    .norm_x_i(nx), .norm_y_i(ny), .norm_z_i(nz), .refr_index_i(idx),
    .valid_o(valid), .reflectance_o(refl), .total_internal_o(tir)
  );

  fresnel_reflectance_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .dir_x_i(dx), .dir_y_i(dy), .dir_z_i(dz),
    .norm_x_i(nx), .norm_y_i(ny), .norm_z_i(nz), .refr_index_i(idx),
    .valid_i(valid), .reflectance_i(refl), .total_internal_i(tir),
    .fail_count_o(fail_count), .pending_o(pending), .tir_seen_o(tir_seen),
    .results_seen_o(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: too long with no transaction and no result ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  // Present one ray and hold it until the block takes it.
  task automatic send_ray(logic [15:0] a, b, c, d, e, f, g);
    dx <= a; dy <= b; dz <= c; nx <= d; ny <= e; nz <= f; idx <= g;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    ray_count++;
  endtask

  // Drop start for an idle burst of random length.
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  // Near-unit vector component in Q2.14 with some spread.
  function automatic logic [15:0] unit_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    logic [15:0] ix;
    int mode;
    ray_count = 0;
    start = 1'b0;
    {dx, dy, dz, nx, ny, nz, idx} = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: head-on entry and exit, grazing, clamped extremes, index extremes.
    send_ray(16'hC000, 0, 0, 16'h4000, 0, 0, 16'd6144);
    send_ray(16'h4000, 0, 0, 16'h4000, 0, 0, 16'd6144);
    send_ray(16'h4000, 0, 0, 0, 16'h4000, 0, 16'd6144);
    send_ray(16'h4000, 0, 0, 0, 16'h4000, 0, 16'd2048);
    send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd6144);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd6144);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd5000);
    send_ray(16'hC000, 0, 0, 16'h4000, 0, 0, 16'd0);
    send_ray(16'hC000, 0, 0, 16'h4000, 0, 0, 16'd1);
    send_ray(16'hC000, 0, 0, 16'h4000, 0, 0, 16'hFFFF);
    send_ray(16'h4000, 0, 0, 16'h4000, 0, 0, 16'hFFFF);
    send_ray(16'h2D41, 16'h2D41, 0, 16'h4000, 0, 0, 16'd6144);
    send_ray(16'h2D41, 16'h2D41, 0, 16'h4000, 0, 0, 16'd4096);
    send_ray(16'hD2BF, 16'h2D41, 0, 16'h4000, 0, 0, 16'd4096);
    send_ray(16'h0100, 16'h3FF0, 0, 16'h4000, 0, 0, 16'd3000);
    send_ray(16'hFF00, 16'h3FF0, 0, 16'h4000, 0, 0, 16'd6000);
    send_ray(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'hAAAA);
    send_ray(16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 16'hCCCC, 16'h3333, 16'h5555);

    // Let the pipeline drain completely once.
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    // Random rays: mostly near-unit vectors with plausible indices.
    for (int n = 0; n < RANDOM_RAYS; n++) begin
      if (n < RANDOM_RAYS - 200 && $urandom_range(0, 3) == 0) idle_burst();
      mode = $urandom_range(0, 9);
      if (mode < 6) ix = 16'($urandom_range(2048, 12288));
      else if (mode < 8) ix = 16'($urandom_range(0, 65535));
      else ix = 16'($urandom_range(4000, 4200));
      if (mode == 9)
        send_ray(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), ix);
      else
        send_ray(unit_comp(), unit_comp() >>> 1, unit_comp() >>> 2,
                 unit_comp(), unit_comp() >>> 2, unit_comp() >>> 1, ix);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d rays, %0d results checked, %0d with total internal reflection.",
             ray_count, results_seen, tir_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
